FILE: src/zvd_pkg.sv
package zvd_pkg;

    localparam int NUM_AXES = 3;
    localparam int DELAY_W  = 6;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_FILL = 5'b00010,
        ST_RD1  = 5'b00100,
        ST_RD2  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

endpackage

FILE: src/zvd_hist_mem.sv
module zvd_hist_mem #(
    parameter int DEPTH = 72,
    parameter int WIDTH = 32,
    parameter int AW    = 7
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [AW-1:0]                       waddr,
    input  logic [zvd_pkg::NUM_AXES*WIDTH-1:0]  wdata,
    input  logic                                re,
    input  logic [AW-1:0]                       raddr_a,
    input  logic [AW-1:0]                       raddr_b,
    output logic [zvd_pkg::NUM_AXES*WIDTH-1:0]  rdata_a,
    output logic [zvd_pkg::NUM_AXES*WIDTH-1:0]  rdata_b
);

    logic [zvd_pkg::NUM_AXES*WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: src/zvd_shape.sv
module zvd_shape #(
    parameter int WIDTH = 32
) (
    input  logic signed [WIDTH-1:0] x0,
    input  logic signed [WIDTH-1:0] x1,
    input  logic signed [WIDTH-1:0] x2,
    output logic signed [WIDTH-1:0] y
);

    localparam logic signed [WIDTH+1:0] TWO  = 2;
    localparam logic signed [WIDTH+1:0] FOUR = 4;

    logic signed [WIDTH+1:0] e0;
    logic signed [WIDTH+1:0] e1;
    logic signed [WIDTH+1:0] e2;
    logic signed [WIDTH+1:0] sum;

    // each term truncates toward zero
    assign e0  = {{2{x0[WIDTH-1]}}, x0};
    assign e1  = {{2{x1[WIDTH-1]}}, x1};
    assign e2  = {{2{x2[WIDTH-1]}}, x2};
    assign sum = (e0 / FOUR) + (e1 / TWO) + (e2 / FOUR);
    assign y   = sum[WIDTH-1:0];

endmodule

FILE: src/three_axis_zvd_input_shaper.sv
// Normal word: history write on accept, two tap reads (RD1, RD2), output load in DONE once
// the output register is free; the next word can be accepted in the cycle after that load.
// Fill word: all HISTORY_DEPTH entries written, one history entry per cycle through
// the memory write port; the raw samples are then passed through.
// Input is held off while a word is in flight, also while it waits in DONE for the output register.
// Reset (async, rst_n low) clears control only; the first word after reset is a fill.
module three_axis_zvd_input_shaper #(
    parameter int HISTORY_DEPTH = 72,
    parameter int MAX_DELAY     = 35,
    parameter int SAMPLE_WIDTH  = 32,
    localparam int IN_BITS      = zvd_pkg::NUM_AXES*SAMPLE_WIDTH + 2*zvd_pkg::DELAY_W,
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS     = zvd_pkg::NUM_AXES*SAMPLE_WIDTH,
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // sample_left, sample_right, sample_yaw, yaw_delay, joint_delay, zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // reset_fill
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // shaped_left, shaped_right, shaped_yaw, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int W     = SAMPLE_WIDTH;
    localparam int AW    = $clog2(HISTORY_DEPTH);
    localparam int HALF  = (HISTORY_DEPTH - 1) / 2;
    localparam int LIM   = (MAX_DELAY < HALF) ? MAX_DELAY : HALF;
    localparam int DW    = (LIM < 1) ? 1 : $clog2(LIM + 1);
    localparam int MW    = zvd_pkg::NUM_AXES * W;
    localparam int DLY_W = zvd_pkg::DELAY_W;
    localparam logic [AW-1:0] LAST = AW'(HISTORY_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_X = (AW+1)'(HISTORY_DEPTH);
    localparam logic [7:0]    LIM8 = 8'(LIM);

    zvd_pkg::state_t state_reg, state_next;

    logic [AW-1:0]          pos_reg, pos_next;
    logic [AW-1:0]          cnt_reg, cnt_next;
    logic                   filled_reg, filled_next;
    logic                   fill_reg, fill_next;
    logic [MW-1:0]          smp_reg, smp_next;
    logic [DW-1:0]          jd_reg, jd_next;
    logic [DW-1:0]          yd_reg, yd_next;
    logic [MW-1:0]          tap1_reg, tap1_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                   accept;
    logic                   out_free;
    logic [MW-1:0]          in_smp;
    logic [DW-1:0]          in_yd;
    logic [DW-1:0]          in_jd;
    logic [AW-1:0]          pos_dec;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [MW-1:0]          mem_wdata;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr_a;
    logic [AW-1:0]          mem_raddr_b;
    logic [MW-1:0]          mem_rdata_a;
    logic [MW-1:0]          mem_rdata_b;

    logic [AW-1:0]          a1_j, a1_y, a2_j, a2_y;
    logic [W-1:0]           shp_l, shp_r, shp_y;

    function automatic logic [DW-1:0] sat_delay(input logic [DLY_W-1:0] d);
        logic [7:0] e;
        begin
            e = 8'(d);
            sat_delay = (e > LIM8) ? DW'(LIM8) : DW'(e);
        end
    endfunction

    // (pos + off) mod depth, off < depth
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p,
                                               input logic [AW:0]   off);
        logic [AW:0] s;
        begin
            s = {1'b0, p} + off;
            if (s >= DEPTH_X)
            begin
                s = s - DEPTH_X;
            end
            wrap_add = s[AW-1:0];
        end
    endfunction

    assign in_smp  = s_tdata[MW-1:0];
    assign in_yd   = sat_delay(s_tdata[MW +: DLY_W]);
    assign in_jd   = sat_delay(s_tdata[MW+DLY_W +: DLY_W]);
    assign pos_dec = (pos_reg == '0) ? LAST : pos_reg - AW'(1);

    assign s_tready = (state_reg == zvd_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign a1_j = wrap_add(pos_reg, (AW+1)'(jd_reg));
    assign a1_y = wrap_add(pos_reg, (AW+1)'(yd_reg));
    assign a2_j = wrap_add(pos_reg, (AW+1)'(jd_reg) << 1);
    assign a2_y = wrap_add(pos_reg, (AW+1)'(yd_reg) << 1);

    always_comb
    begin
        mem_we      = 1'b0;
        mem_waddr   = pos_dec;
        mem_wdata   = in_smp;
        mem_re      = 1'b0;
        mem_raddr_a = a1_j;
        mem_raddr_b = a1_y;
        if (state_reg == zvd_pkg::ST_FILL)
        begin
            mem_we    = 1'b1;
            mem_waddr = cnt_reg;
            mem_wdata = smp_reg;
        end
        else if (accept && !(s_tuser || !filled_reg))
        begin
            mem_we = 1'b1;
        end
        if (state_reg == zvd_pkg::ST_RD1)
        begin
            mem_re = 1'b1;
        end
        else if (state_reg == zvd_pkg::ST_RD2)
        begin
            mem_re      = 1'b1;
            mem_raddr_a = a2_j;
            mem_raddr_b = a2_y;
        end
    end

    zvd_hist_mem #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (W),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    zvd_shape #(.WIDTH(W)) u_shape_l (
        .x0 (smp_reg[0 +: W]),
        .x1 (tap1_reg[0 +: W]),
        .x2 (mem_rdata_a[0 +: W]),
        .y  (shp_l)
    );

    zvd_shape #(.WIDTH(W)) u_shape_r (
        .x0 (smp_reg[W +: W]),
        .x1 (tap1_reg[W +: W]),
        .x2 (mem_rdata_a[W +: W]),
        .y  (shp_r)
    );

    zvd_shape #(.WIDTH(W)) u_shape_y (
        .x0 (smp_reg[2*W +: W]),
        .x1 (tap1_reg[2*W +: W]),
        .x2 (mem_rdata_b[2*W +: W]),
        .y  (shp_y)
    );

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        filled_next   = filled_reg;
        fill_next     = fill_reg;
        smp_next      = smp_reg;
        jd_next       = jd_reg;
        yd_next       = yd_reg;
        tap1_next     = tap1_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            zvd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    smp_next = in_smp;
                    jd_next  = in_jd;
                    yd_next  = in_yd;
                    if (s_tuser || !filled_reg)
                    begin
                        fill_next   = 1'b1;
                        filled_next = 1'b1;
                        pos_next    = '0;
                        cnt_next    = '0;
                        state_next  = zvd_pkg::ST_FILL;
                    end
                    else
                    begin
                        fill_next  = 1'b0;
                        pos_next   = pos_dec;
                        state_next = zvd_pkg::ST_RD1;
                    end
                end
            end
            zvd_pkg::ST_FILL:
            begin
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == LAST)
                begin
                    state_next = zvd_pkg::ST_DONE;
                end
            end
            zvd_pkg::ST_RD1:
            begin
                state_next = zvd_pkg::ST_RD2;
            end
            zvd_pkg::ST_RD2:
            begin
                tap1_next = {mem_rdata_b[2*W +: W], mem_rdata_a[0 +: 2*W]};
                state_next = zvd_pkg::ST_DONE;
            end
            zvd_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    if (fill_reg)
                    begin
                        m_tdata_next = OUT_TDATA_W'(smp_reg);
                    end
                    else
                    begin
                        m_tdata_next = OUT_TDATA_W'({shp_y, shp_r, shp_l});
                    end
                    state_next = zvd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = zvd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= zvd_pkg::ST_IDLE;
            pos_reg      <= '0;
            filled_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            filled_reg   <= filled_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        fill_reg    <= fill_next;
        smp_reg     <= smp_next;
        jd_reg      <= jd_next;
        yd_reg      <= yd_next;
        tap1_reg    <= tap1_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
